@@ rtl/goertzel_tone_strength_defines.svh @@
`ifndef GOERTZEL_TONE_STRENGTH_DEFINES_SVH
`define GOERTZEL_TONE_STRENGTH_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gts_pkg.sv @@
package gts_pkg;

  localparam int SMP_W     = 16;
  localparam int ST_W      = 48;
  localparam int COEF_B_W  = 19;
  localparam int COEF_W    = 18;
  localparam int NW        = 13;
  localparam int OUT_W     = 40;
  localparam int Y_W       = 54;
  localparam int FRAC_SH   = 16;
  localparam int X_SH      = 8;

  // digit-serial multiplier
  localparam int MA_W      = 56;
  localparam int DIG_W     = 4;
  localparam int NDIG      = MA_W / DIG_W;
  localparam int PROD_W    = 2 * MA_W;

  localparam int SUM_W     = 108;
  localparam int DVS_SH    = 7;
  localparam int DVS_W     = 2 * NW + DVS_SH;

  localparam int GTS_MAX_BLOCK = 4096;
  localparam logic [NW-1:0] BLK_RST = NW'(205);

  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int RI_W      = 3;

  localparam logic [RI_W-1:0] REG_COEF_B    = 3'd0;
  localparam logic [RI_W-1:0] REG_C_REAL    = 3'd1;
  localparam logic [RI_W-1:0] REG_C_IMAG    = 3'd2;
  localparam logic [RI_W-1:0] REG_D_REAL    = 3'd3;
  localparam logic [RI_W-1:0] REG_D_IMAG    = 3'd4;
  localparam logic [RI_W-1:0] REG_BLOCK_LEN = 3'd5;

endpackage

@@ rtl/gts_mul.sv @@
module gts_mul
  import gts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic signed [MA_W-1:0]   a,
  input  logic signed [MA_W-1:0]   b,
  output logic                     done,
  output logic [PROD_W-1:0]        prod
);

  localparam int DC_W = $clog2(NDIG);

  logic [MA_W-1:0]           sh_r, sh_nxt;
  logic signed [MA_W-1:0]    b_r, b_nxt;
  logic signed [MA_W+DIG_W:0] acc_r, acc_nxt;
  logic [DC_W-1:0]           cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic [DIG_W-1:0]          dig;
  logic                      top_dig;
  logic signed [DIG_W:0]     dsg;
  logic signed [MA_W+DIG_W:0] pp;
  logic signed [MA_W+DIG_W:0] sum;

  // a is consumed low digit first; product digits fill sh_r from the top
  always_comb begin
    dig     = sh_r[DIG_W-1:0];
    top_dig = (cnt_r == DC_W'(NDIG - 1));
    dsg     = top_dig ? $signed({dig[DIG_W-1], dig}) : $signed({1'b0, dig});
    pp      = dsg * b_r;
    sum     = acc_r + pp;

    sh_nxt   = sh_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (go) begin
      sh_nxt   = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sum[DIG_W-1:0], sh_r[MA_W-1:DIG_W]};
      acc_nxt = sum >>> DIG_W;
      cnt_nxt = cnt_r + 1'b1;
      if (top_dig) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign prod = {acc_r[MA_W-1:0], sh_r};

endmodule

@@ rtl/gts_div.sv @@
module gts_div
  import gts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [SUM_W-1:0]   num,
  input  logic [DVS_W-1:0]   dvs,
  output logic               done,
  output logic [OUT_W-1:0]   quo
);

  localparam int CNT_W = $clog2(OUT_W);
  localparam int HI_W  = SUM_W - OUT_W;

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [OUT_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DVS_W:0]   r2;
  logic [DVS_W:0]   diff;
  logic             ge;

  // quotient >= 2^OUT_W exactly when num / 2^OUT_W >= dvs; else the
  // partial remainder starts below dvs and OUT_W restoring steps finish it
  always_comb begin
    r2   = {rem_r, q_r[OUT_W-1]};
    diff = r2 - {1'b0, dvs_r};
    ge   = (r2 >= {1'b0, dvs_r});

    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (go) begin
      dvs_nxt = dvs;
      cnt_nxt = '0;
      if (num[SUM_W-1:OUT_W] >= HI_W'(dvs)) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = num[OUT_W +: DVS_W];
        q_nxt    = num[OUT_W-1:0];
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : r2[DVS_W-1:0];
      q_nxt   = {q_r[OUT_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(OUT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/goertzel_tone_strength.sv @@
// Goertzel single-bin tone detector. Samples arrive on in_tdata with in_tlast marking the
// final sample of a block; that sample produces one out_tdata word holding 2*|y|^2/N^2 as
// unsigned Q32.8, saturated. All products go through one 4-bit-digit serial multiplier, and
// a new sample is not taken until the multiplier has finished with the one before. A sample
// marked last runs nine products and a 40-step bit-serial divide; the divide steps are
// skipped when the quotient saturates or N is zero. The next block's first sample is taken
// as soon as the result has been loaded into the output register, even while that word is
// still waiting. An earlier word still waiting in the output register holds off the load
// until it is taken. The coefficients and block length must be written through the cfg_ APB
// port only while idle; the block does not enforce this. block_len above MAX_BLOCK is
// clamped, and a block length of zero gives all ones.
module goertzel_tone_strength
  import gts_pkg::*;
#(
  parameter int MAX_BLOCK = GTS_MAX_BLOCK
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SMP_W-1:0]    in_tdata,     // [15:0] sample
  input  logic                in_tlast,

  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,    // [39:0] strength

  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  localparam logic [NW-1:0] N_CAP =
    (MAX_BLOCK >= (1 << NW)) ? {NW{1'b1}} : NW'(MAX_BLOCK);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  typedef enum logic [3:0] {
    OP_B, OP_CR, OP_CI, OP_YR1, OP_YR2, OP_SQR, OP_YI1, OP_YI2, OP_SQI
  } op_t;

  state_t                       state_r, state_nxt;
  op_t                          op_r, op_nxt;
  logic                         mul_go_r, mul_go_nxt;
  logic                         div_go_r, div_go_nxt;
  logic signed [SMP_W-1:0]      x_r, x_nxt;
  logic                         last_r, last_nxt;
  logic signed [ST_W-1:0]       s1_r, s1_nxt;
  logic signed [ST_W-1:0]       s2_r, s2_nxt;
  logic signed [Y_W-1:0]        t_r, t_nxt;
  logic signed [Y_W-1:0]        ya_r, ya_nxt;
  logic signed [Y_W-1:0]        yb_r, yb_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [DVS_W-1:0]             dvs_r, dvs_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]             out_dat_r, out_dat_nxt;

  logic signed [COEF_B_W-1:0]   cb_r;
  logic signed [COEF_W-1:0]     cr_r;
  logic signed [COEF_W-1:0]     ci_r;
  logic signed [COEF_W-1:0]     dr_r;
  logic signed [COEF_W-1:0]     di_r;
  logic [NW-1:0]                blk_r;

  logic signed [MA_W-1:0]       mul_a;
  logic signed [MA_W-1:0]       mul_b;
  logic                         mul_done;
  logic [PROD_W-1:0]            mul_prod;
  logic                         div_done;
  logic [OUT_W-1:0]             div_quo;

  logic signed [Y_W-1:0]        q16;
  logic signed [ST_W-1:0]       xs;
  logic signed [ST_W-1:0]       s0;
  logic [NW-1:0]                n_eff;
  logic [2*NW-1:0]              n_sq;
  logic [RI_W-1:0]              cfg_idx;
  logic                         cfg_wr;

  gts_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  gts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .num   (sum_r),
    .dvs   (dvs_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // operands follow the op being started
  always_comb begin
    case (op_r)
      OP_B: begin
        mul_a = MA_W'(s1_r);
        mul_b = MA_W'(cb_r);
      end
      OP_CR: begin
        mul_a = MA_W'(s1_r);
        mul_b = MA_W'(cr_r);
      end
      OP_CI: begin
        mul_a = MA_W'(s1_r);
        mul_b = MA_W'(ci_r);
      end
      OP_YR1: begin
        mul_a = MA_W'(ya_r);
        mul_b = MA_W'(dr_r);
      end
      OP_YR2: begin
        mul_a = MA_W'(yb_r);
        mul_b = MA_W'(di_r);
      end
      OP_YI1: begin
        mul_a = MA_W'(ya_r);
        mul_b = MA_W'(di_r);
      end
      OP_YI2: begin
        mul_a = MA_W'(yb_r);
        mul_b = MA_W'(dr_r);
      end
      OP_SQR, OP_SQI: begin
        mul_a = MA_W'(t_r);
        mul_b = MA_W'(t_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    q16   = $signed(mul_prod[FRAC_SH +: Y_W]);
    xs    = $signed({{(ST_W-SMP_W-X_SH){x_r[SMP_W-1]}}, x_r, {X_SH{1'b0}}});
    s0    = $signed(mul_prod[FRAC_SH +: ST_W]) + xs - s2_r;
    n_eff = (blk_r > N_CAP) ? N_CAP : blk_r;
    n_sq  = n_eff * n_eff;

    state_nxt   = state_r;
    op_nxt      = op_r;
    mul_go_nxt  = 1'b0;
    div_go_nxt  = 1'b0;
    x_nxt       = x_r;
    last_nxt    = last_r;
    s1_nxt      = s1_r;
    s2_nxt      = s2_r;
    t_nxt       = t_r;
    ya_nxt      = ya_r;
    yb_nxt      = yb_r;
    sum_nxt     = sum_r;
    dvs_nxt     = dvs_r;
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt      = $signed(in_tdata);
          last_nxt   = in_tlast;
          dvs_nxt    = {n_sq, {DVS_SH{1'b0}}};
          op_nxt     = OP_B;
          mul_go_nxt = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          mul_go_nxt = 1'b1;
          case (op_r)
            OP_B: begin
              if (!last_r) begin
                s2_nxt     = s1_r;
                s1_nxt     = s0;
                mul_go_nxt = 1'b0;
                state_nxt  = S_IDLE;
              end else begin
                t_nxt  = Y_W'(s0);
                op_nxt = OP_CR;
              end
            end
            OP_CR: begin
              ya_nxt = t_r - q16;
              op_nxt = OP_CI;
            end
            OP_CI: begin
              yb_nxt = q16;
              s1_nxt = '0;
              s2_nxt = '0;
              op_nxt = OP_YR1;
            end
            OP_YR1: begin
              t_nxt  = q16;
              op_nxt = OP_YR2;
            end
            OP_YR2: begin
              t_nxt  = t_r - q16;
              op_nxt = OP_SQR;
            end
            OP_SQR: begin
              sum_nxt = mul_prod[SUM_W-1:0];
              op_nxt  = OP_YI1;
            end
            OP_YI1: begin
              t_nxt  = q16;
              op_nxt = OP_YI2;
            end
            OP_YI2: begin
              t_nxt  = t_r + q16;
              op_nxt = OP_SQI;
            end
            OP_SQI: begin
              sum_nxt    = sum_r + mul_prod[SUM_W-1:0];
              mul_go_nxt = 1'b0;
              div_go_nxt = 1'b1;
              state_nxt  = S_DIV;
            end
            default: begin
              mul_go_nxt = 1'b0;
              state_nxt  = S_IDLE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_dat_nxt = div_quo;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cfg_idx = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= OP_B;
      mul_go_r  <= 1'b0;
      div_go_r  <= 1'b0;
      s1_r      <= '0;
      s2_r      <= '0;
      out_vld_r <= 1'b0;
      cb_r      <= '0;
      cr_r      <= '0;
      ci_r      <= '0;
      dr_r      <= '0;
      di_r      <= '0;
      blk_r     <= BLK_RST;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      mul_go_r  <= mul_go_nxt;
      div_go_r  <= div_go_nxt;
      s1_r      <= s1_nxt;
      s2_r      <= s2_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_COEF_B:    cb_r  <= $signed(cfg_pwdata[COEF_B_W-1:0]);
          REG_C_REAL:    cr_r  <= $signed(cfg_pwdata[COEF_W-1:0]);
          REG_C_IMAG:    ci_r  <= $signed(cfg_pwdata[COEF_W-1:0]);
          REG_D_REAL:    dr_r  <= $signed(cfg_pwdata[COEF_W-1:0]);
          REG_D_IMAG:    di_r  <= $signed(cfg_pwdata[COEF_W-1:0]);
          REG_BLOCK_LEN: blk_r <= cfg_pwdata[NW-1:0];
          default: ;
        endcase
      end
    end
    x_r       <= x_nxt;
    last_r    <= last_nxt;
    t_r       <= t_nxt;
    ya_r      <= ya_nxt;
    yb_r      <= yb_nxt;
    sum_r     <= sum_nxt;
    dvs_r     <= dvs_nxt;
    out_dat_r <= out_dat_nxt;
  end

  always_comb begin
    case (cfg_idx)
      REG_COEF_B:    cfg_prdata = {{(CFG_DW-COEF_B_W){1'b0}}, cb_r};
      REG_C_REAL:    cfg_prdata = {{(CFG_DW-COEF_W){1'b0}}, cr_r};
      REG_C_IMAG:    cfg_prdata = {{(CFG_DW-COEF_W){1'b0}}, ci_r};
      REG_D_REAL:    cfg_prdata = {{(CFG_DW-COEF_W){1'b0}}, dr_r};
      REG_D_IMAG:    cfg_prdata = {{(CFG_DW-COEF_W){1'b0}}, di_r};
      REG_BLOCK_LEN: cfg_prdata = {{(CFG_DW-NW){1'b0}}, blk_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

endmodule

@@ rtl/gts_chk.sv @@
`include "goertzel_tone_strength_defines.svh"

module gts_chk
  import gts_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a word is worked on for many cycles, so a second one is never taken right away
  `GTS_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "word taken while busy")

  `GTS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped or changed while stalled")

  // a result is only loaded from the busy side, never straight out of idle
  `GTS_ASSERT_IMP(a_out_from_busy, $rose(out_tvalid), !$past(in_tready), "result appeared while idle")

endmodule

bind goertzel_tone_strength gts_chk u_gts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
